[rtl/lsq_pkg.sv]
// ----------------------------------------------------------------------------
// lsq_pkg
// Shared types, widths and helpers for the largest-square-of-ones block.
// ----------------------------------------------------------------------------
package lsq_pkg;

    localparam int SIDE_W     = 11;
    localparam int AREA_W     = 21;
    localparam int ROW_LEN_W  = 11;
    localparam int MAX_COLS   = 1024;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int Q_DEPTH    = 2;

    localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = ROW_LEN_W'(1024);

    // register index decoded from paddr[APB_ADDR_W-1:2]
    localparam logic REG_ROW_LENGTH = 1'b0;

    typedef logic [SIDE_W-1:0] t_side;

    localparam t_side SIDE_MAX = '1;

    typedef struct packed {
        logic pixel;
        logic last_pixel;
    } t_in;

    typedef struct packed {
        logic [SIDE_W-1:0] max_side;
        logic [AREA_W-1:0] max_area;
    } t_out;

    // classification carried from the front to the back
    typedef struct packed {
        logic pixel;
        logic last_pixel;
        logic first_row;
        logic col_zero;
    } t_cls;

    function automatic t_side min3(input t_side a, input t_side b, input t_side c);
        t_side m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

endpackage

[rtl/lsq_ram.sv]
// ----------------------------------------------------------------------------
// lsq_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module lsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lsq_front.sv]
// ----------------------------------------------------------------------------
// lsq_front
// Accept pixels, track column and first-row position, classify each pixel.
// ----------------------------------------------------------------------------
module lsq_front #(
    parameter int MAX_COLS = lsq_pkg::MAX_COLS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [lsq_pkg::ROW_LEN_W-1:0]   i_row_length,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  lsq_pkg::t_in                    i_in_item,
    input  logic                            i_q_full,
    output logic                            o_push,
    output lsq_pkg::t_cls                   o_cls,
    output logic [$clog2(MAX_COLS)-1:0]     o_col
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int LIM_W  = $clog2(MAX_COLS + 1);
    localparam int LEN_W  = (LIM_W > lsq_pkg::ROW_LEN_W) ? LIM_W : lsq_pkg::ROW_LEN_W;

    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic             r_first;
    logic             n_first;

    logic [LEN_W-1:0] len_raw;
    logic [LEN_W-1:0] len;
    logic             wrap_now;
    logic [COL_W-1:0] col_use;
    logic             first_use;
    logic [LEN_W-1:0] col_inc;
    logic             wrap_after;
    logic             accept;

    assign len_raw = LEN_W'(i_row_length);

    always_comb begin
        if (len_raw == '0) begin
            len = LEN_W'(1);
        end else if (len_raw > LEN_W'(MAX_COLS)) begin
            len = LEN_W'(MAX_COLS);
        end else begin
            len = len_raw;
        end
    end

    assign wrap_now   = LEN_W'(r_col) >= len;
    assign col_use    = wrap_now ? '0 : r_col;
    assign first_use  = wrap_now ? 1'b0 : r_first;
    assign col_inc    = LEN_W'(col_use) + LEN_W'(1);
    assign wrap_after = col_inc >= len;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept;
    assign o_col      = col_use;

    assign o_cls.pixel      = i_in_item.pixel;
    assign o_cls.last_pixel = i_in_item.last_pixel;
    assign o_cls.first_row  = first_use;
    assign o_cls.col_zero   = (col_use == '0);

    always_comb begin
        n_col   = r_col;
        n_first = r_first;
        if (accept) begin
            if (i_in_item.last_pixel) begin
                n_col   = '0;
                n_first = 1'b1;
            end else if (wrap_after) begin
                n_col   = '0;
                n_first = 1'b0;
            end else begin
                n_col   = col_inc[COL_W-1:0];
                n_first = first_use;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_first <= 1'b1;
        end else begin
            r_col   <= n_col;
            r_first <= n_first;
        end
    end

endmodule

[rtl/lsq_queue.sv]
// ----------------------------------------------------------------------------
// lsq_queue
// Short register queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module lsq_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (lsq_pkg::Q_DEPTH > 1) ? $clog2(lsq_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(lsq_pkg::Q_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [lsq_pkg::Q_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(lsq_pkg::Q_DEPTH));
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(lsq_pkg::Q_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(lsq_pkg::Q_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

[rtl/lsq_back.sv]
// ----------------------------------------------------------------------------
// lsq_back
// Compute square sides against the line buffer, keep the running maximum,
// and deliver the result through a result stage and an output register.
// ----------------------------------------------------------------------------
module lsq_back #(
    parameter int MAX_COLS = lsq_pkg::MAX_COLS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  lsq_pkg::t_cls               i_q_cls,
    input  logic [$clog2(MAX_COLS)-1:0] i_q_col,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output lsq_pkg::t_out               o_out_item
);

    localparam int COL_W = $clog2(MAX_COLS);

    // compute stage
    logic             r_c_valid;
    logic             n_c_valid;
    lsq_pkg::t_cls    r_c_cls;
    logic [COL_W-1:0] r_c_col;
    logic             r_fwd;
    lsq_pkg::t_side   r_fwd_side;
    lsq_pkg::t_side   r_left;
    lsq_pkg::t_side   r_diag;
    lsq_pkg::t_side   r_best;

    // result and output stages
    logic             r_r_valid;
    logic             n_r_valid;
    lsq_pkg::t_side   r_r_side;
    logic             r_o_valid;
    logic             n_o_valid;
    lsq_pkg::t_out    r_o_item;

    lsq_pkg::t_side   rdata;
    lsq_pkg::t_side   up;
    lsq_pkg::t_side   m;
    lsq_pkg::t_side   side;
    lsq_pkg::t_side   best_new;
    logic [2*lsq_pkg::SIDE_W-1:0] prod;

    logic o_free;
    logic r_move;
    logic r_free;
    logic c_fire;
    logic c_free;
    logic pop;

    assign o_free = !r_o_valid || !i_out_stall;
    assign r_move = r_r_valid && o_free;
    assign r_free = !r_r_valid || r_move;
    assign c_fire = r_c_valid && (!r_c_cls.last_pixel || r_free);
    assign c_free = !r_c_valid || c_fire;
    assign pop    = i_q_valid && c_free;
    assign o_pop  = pop;

    lsq_ram #(
        .WIDTH (lsq_pkg::SIDE_W),
        .DEPTH (MAX_COLS)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (c_fire),
        .i_waddr (r_c_col),
        .i_wdata (side),
        .i_re    (pop),
        .i_raddr (i_q_col),
        .o_rdata (rdata)
    );

    always_comb begin
        if (r_c_cls.first_row) begin
            up = '0;
        end else if (r_fwd) begin
            up = r_fwd_side;
        end else begin
            up = rdata;
        end
        m = lsq_pkg::min3(up, r_left, r_diag);
        if (!r_c_cls.pixel) begin
            side = '0;
        end else if (r_c_cls.first_row || r_c_cls.col_zero) begin
            side = lsq_pkg::SIDE_W'(1);
        end else if (m == lsq_pkg::SIDE_MAX) begin
            side = m;
        end else begin
            side = m + lsq_pkg::SIDE_W'(1);
        end
        best_new = (side > r_best) ? side : r_best;
    end

    assign n_c_valid = pop || (r_c_valid && !c_fire);
    assign n_r_valid = (c_fire && r_c_cls.last_pixel) || (r_r_valid && !r_move);
    assign n_o_valid = r_move || (r_o_valid && i_out_stall);
    assign prod      = (2*lsq_pkg::SIDE_W)'(r_r_side) * (2*lsq_pkg::SIDE_W)'(r_r_side);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_r_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_best    <= '0;
            r_fwd     <= 1'b0;
        end else begin
            r_c_valid <= n_c_valid;
            r_r_valid <= n_r_valid;
            r_o_valid <= n_o_valid;
            if (c_fire) begin
                r_best <= r_c_cls.last_pixel ? '0 : best_new;
            end
            if (pop) begin
                r_fwd <= c_fire && (r_c_col == i_q_col);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_c_cls    <= i_q_cls;
            r_c_col    <= i_q_col;
            r_fwd_side <= side;
        end
        if (c_fire) begin
            r_left <= side;
            r_diag <= up;
            if (r_c_cls.last_pixel) begin
                r_r_side <= best_new;
            end
        end
        if (r_move) begin
            r_o_item.max_side <= r_r_side;
            r_o_item.max_area <= prod[lsq_pkg::AREA_W-1:0];
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;

endmodule

[rtl/largest_square_of_ones.sv]
// ----------------------------------------------------------------------------
// largest_square_of_ones
// Finds the largest all-ones square in a binary image streamed in raster order.
// ----------------------------------------------------------------------------
// Input channel: one pixel per transaction (pixel, last_pixel), taken when
// i_in_valid is high and o_in_stall is low. Rows are row_length pixels long,
// set through the APB port at byte address 0 (reset value 1024, 0 acts as 1,
// values above MAX_COLS act as MAX_COLS). Write it only while the block is idle.
// Output channel: one transaction per image, carrying max_side and max_area,
// delivered after the pixel flagged last_pixel.
// Throughput: one pixel per clock while i_out_stall does not hold the result
// path. The line buffer is a RAM with one write and one registered read per
// cycle; a bypass covers one-pixel rows. After the last pixel is accepted, the
// result passes the queue, compute, result and output (with multiplier) stages.
// A two-entry queue sits between the front and the compute back end;
// o_in_stall is high only while that queue is full.
// When i_out_stall is high the result holds and the back end fills up; the
// front keeps taking pixels until the queue is full.
// Reset clears the position, running maximum and all valid flags; the line
// buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module largest_square_of_ones #(
    parameter int MAX_COLS = lsq_pkg::MAX_COLS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  lsq_pkg::t_in                     i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output lsq_pkg::t_out                    o_out_item,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lsq_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lsq_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lsq_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int Q_W   = $bits(lsq_pkg::t_cls) + COL_W;

    logic [lsq_pkg::ROW_LEN_W-1:0] r_row_length;

    logic             push;
    lsq_pkg::t_cls    f_cls;
    logic [COL_W-1:0] f_col;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic [Q_W-1:0]   q_data;
    lsq_pkg::t_cls    q_cls;
    logic [COL_W-1:0] q_col;

    assign pready = 1'b1;
    assign prdata = lsq_pkg::APB_DATA_W'(r_row_length);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= lsq_pkg::ROW_LEN_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[lsq_pkg::APB_ADDR_W-1:2] == lsq_pkg::REG_ROW_LENGTH)) begin
            r_row_length <= pwdata[lsq_pkg::ROW_LEN_W-1:0];
        end
    end

    lsq_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_row_length (r_row_length),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cls        (f_cls),
        .o_col        (f_col)
    );

    lsq_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cls, f_col}),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_data)
    );

    assign q_cls = q_data[Q_W-1:COL_W];
    assign q_col = q_data[COL_W-1:0];

    lsq_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cls     (q_cls),
        .i_q_col     (q_col),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[rtl/lsq_checker.sv]
// ----------------------------------------------------------------------------
// lsq_checker
// Port-level checks for the largest-square-of-ones block, bound to the top.
// ----------------------------------------------------------------------------
module lsq_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input lsq_pkg::t_in                     i_in_item,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input lsq_pkg::t_out                    o_out_item,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [lsq_pkg::APB_ADDR_W-1:0]   paddr,
    input logic [lsq_pkg::APB_DATA_W-1:0]   pwdata,
    input logic [lsq_pkg::APB_DATA_W-1:0]   prdata,
    input logic                             pready
);

    logic [2*lsq_pkg::SIDE_W-1:0] sq;

    assign sq = (2*lsq_pkg::SIDE_W)'(o_out_item.max_side)
              * (2*lsq_pkg::SIDE_W)'(o_out_item.max_side);

    a_area_matches_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.max_area == sq[lsq_pkg::AREA_W-1:0]))
        else $error("max_area is not max_side squared");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after reset");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready
         && (paddr[lsq_pkg::APB_ADDR_W-1:2] == lsq_pkg::REG_ROW_LENGTH))
        |=> (prdata[lsq_pkg::ROW_LEN_W-1:0] == $past(pwdata[lsq_pkg::ROW_LEN_W-1:0])))
        else $error("row_length read-back mismatch");

endmodule

bind largest_square_of_ones lsq_checker u_lsq_checker (.*);
